// ----- hdl/fwra_pkg.sv -----
package fwra_pkg;

    // fixed field widths
    localparam int IDX_W = 13;
    localparam int VAL_W = 32;
    localparam int SUM_W = 64;

    // walk index width: an upward walk may step to twice the size in use
    localparam int NODE_W = IDX_W + 1;

    localparam logic [IDX_W-1:0] SIZE_RESET = 13'd4096;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // classified command handed to the back end
    typedef struct packed {
        op_t                     op;
        logic [NODE_W-1:0]       node_first;   // left index, or clamped query index
        logic [NODE_W-1:0]       node_second;  // right index + 1 for an add
        logic [NODE_W-1:0]       limit;        // effective size
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UP_LEFT,
        ST_UP_RIGHT,
        ST_DOWN,
        ST_DRAIN
    } back_state_t;

endpackage

// ----- hdl/fwra_front.sv -----
module fwra_front
    import fwra_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic [IDX_W-1:0]        s_left_index,
    input  logic [IDX_W-1:0]        s_right_index,
    input  logic signed [VAL_W-1:0] s_add_value,
    input  logic                    clear_done,
    output logic                    cmd_valid,
    output cmd_t                    cmd,
    input  logic                    cmd_ready
);

    logic [IDX_W-1:0]  size_reg;
    logic [IDX_W-1:0]  size_next;
    logic [NODE_W-1:0] limit;
    logic [NODE_W-1:0] left_node;
    logic [NODE_W-1:0] query_node;
    logic              is_add;
    logic              drop;

    // size register
    always_comb begin
        size_next = size_reg;
        if (cfg_wr_en) begin
            size_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else begin
            size_reg <= size_next;
        end
    end

    // effective size, capped at the store depth
    always_comb begin
        if (32'(size_reg) > 32'(MAX_ENTRIES)) begin
            limit = NODE_W'(MAX_ENTRIES);
        end else begin
            limit = NODE_W'(size_reg);
        end
    end

    // classify the incoming word
    assign is_add     = (s_operation == OP_ADD);
    assign left_node  = NODE_W'(s_left_index);
    assign drop       = is_add && ((s_left_index == '0) || (s_left_index > s_right_index));
    assign query_node = (left_node > limit) ? limit : left_node;

    always_comb begin
        cmd.op          = is_add ? OP_ADD : OP_QUERY;
        cmd.node_first  = is_add ? left_node : query_node;
        cmd.node_second = NODE_W'(s_right_index) + NODE_W'(1);
        cmd.limit       = limit;
        cmd.value       = s_add_value;
    end

    // dropped adds are taken without reaching the queue
    assign s_ready   = clear_done && cmd_ready;
    assign cmd_valid = s_valid && clear_done && !drop;

endmodule

// ----- hdl/fwra_queue.sv -----
module fwra_queue
    import fwra_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    cmd_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/fwra_back.sv -----
module fwra_back
    import fwra_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cmd_valid,
    input  cmd_t                    cmd,
    output logic                    cmd_ready,
    output logic                    clear_done,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUM_W-1:0] m_point_value
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_ENTRIES - 1);

    logic [SUM_W-1:0] mem [MAX_ENTRIES];

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [ADDR_W-1:0]       clr_cnt_reg;
    logic [NODE_W-1:0]       node_reg;
    logic [NODE_W-1:0]       node_second_reg;
    logic [NODE_W-1:0]       limit_reg;
    logic signed [VAL_W-1:0] value_reg;
    op_t                     op_reg;
    logic                    p_valid_reg;
    logic [ADDR_W-1:0]       p_addr_reg;
    logic                    p_neg_reg;
    logic                    byp_reg;
    logic [SUM_W-1:0]        byp_data_reg;
    logic [SUM_W-1:0]        rdata_reg;
    logic [SUM_W-1:0]        acc_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SUM_W-1:0]        out_data_reg;

    logic [NODE_W-1:0] low_bit;
    logic              up_live;
    logic              down_live;
    logic              pop;
    logic              issue;
    logic              finish;
    logic [ADDR_W-1:0] raddr;
    logic [SUM_W-1:0]  data_now;
    logic [SUM_W-1:0]  value_ext;
    logic [SUM_W-1:0]  sum_up;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SUM_W-1:0]  wdata;

    // walk helpers
    assign low_bit   = node_reg & (~node_reg + NODE_W'(1));
    assign up_live   = (node_reg != '0) && (node_reg <= limit_reg);
    assign down_live = (node_reg != '0);
    assign raddr     = ADDR_W'(node_reg - NODE_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    state_next = (cmd.op == OP_ADD) ? ST_UP_LEFT : ST_DOWN;
                end
            end
            ST_UP_LEFT: begin
                if (!up_live) begin
                    state_next = ST_UP_RIGHT;
                end
            end
            ST_UP_RIGHT: begin
                if (!up_live) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DOWN: begin
                if (!down_live) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!p_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop    = 1'b0;
        issue  = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            ST_CLEAR: ;
            ST_IDLE: begin
                pop = cmd_valid && ((cmd.op == OP_ADD) || !out_valid_reg);
            end
            ST_UP_LEFT, ST_UP_RIGHT: begin
                issue = up_live;
            end
            ST_DOWN: begin
                issue = down_live;
            end
            ST_DRAIN: begin
                finish = !p_valid_reg;
            end
            default: ;
        endcase
    end

    assign cmd_ready  = pop;
    assign clear_done = (state_reg != ST_CLEAR);

    // read-modify-write path, with bypass of a same-cycle write
    assign data_now  = byp_reg ? byp_data_reg : rdata_reg;
    assign value_ext = {{(SUM_W - VAL_W){value_reg[VAL_W-1]}}, value_reg};
    assign sum_up    = p_neg_reg ? (data_now - value_ext) : (data_now + value_ext);

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end else begin
            we    = p_valid_reg && (op_reg == OP_ADD);
            waddr = p_addr_reg;
            wdata = sum_up;
        end
    end

    // tree store
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (finish && (op_reg == OP_QUERY)) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            p_valid_reg   <= issue;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // walk and accumulate datapath
    always_ff @(posedge aclk) begin
        if (pop) begin
            node_reg        <= cmd.node_first;
            node_second_reg <= cmd.node_second;
            limit_reg       <= cmd.limit;
            value_reg       <= cmd.value;
            op_reg          <= cmd.op;
            acc_reg         <= '0;
        end else begin
            if (issue) begin
                node_reg <= (state_reg == ST_DOWN) ? (node_reg - low_bit)
                                                   : (node_reg + low_bit);
            end else if (state_reg == ST_UP_LEFT) begin
                node_reg <= node_second_reg;
            end
            if (p_valid_reg && (op_reg == OP_QUERY)) begin
                acc_reg <= acc_reg + data_now;
            end
        end
        p_addr_reg   <= raddr;
        p_neg_reg    <= (state_reg == ST_UP_RIGHT);
        byp_reg      <= we && (waddr == raddr);
        byp_data_reg <= wdata;
        // only a query loads the result word, so a waiting word holds through adds
        if (finish && (op_reg == OP_QUERY)) begin
            out_data_reg <= acc_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_point_value = out_data_reg;

endmodule

// ----- hdl/fenwick_range_add_point_query_top.sv -----
// a query word returns the sum along its downward walk, n nodes long (at most 12); an add
// occupies the back end for two upward walks of n1 and n2 nodes, a query for its one walk;
// throughput: one tree node per cycle during a walk, set by the single
// read and write port of the store
// reset: synchronous, active low; afterwards a clearing pass zeroes every entry of
// the store with s_ready held low, and the size register returns to 4096
module fenwick_range_add_point_query_top
    import fwra_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic [IDX_W-1:0]        s_left_index,
    input  logic [IDX_W-1:0]        s_right_index,
    input  logic signed [VAL_W-1:0] s_add_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUM_W-1:0] m_point_value
);

    logic clear_done;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // word intake and classification
    fwra_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_left_index  (s_left_index),
        .s_right_index (s_right_index),
        .s_add_value   (s_add_value),
        .clear_done    (clear_done),
        .cmd_valid     (push_valid),
        .cmd           (push_cmd),
        .cmd_ready     (push_ready)
    );

    // command queue
    fwra_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // tree walks over the store
    fwra_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (pop_valid),
        .cmd           (pop_cmd),
        .cmd_ready     (pop_ready),
        .clear_done    (clear_done),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_value (m_point_value)
    );

endmodule

// ----- hdl/fwra_checker.sv -----
module fwra_checker
    import fwra_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [SUM_W-1:0] m_point_value
);

    // no result word right after reset
    a_no_word_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("result valid right after reset");

    // clearing pass blocks intake right after reset
    a_clear_blocks_intake: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
    else $error("input ready during clearing pass");

    // a stalled result word holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_value))
    else $error("result word changed while stalled");

endmodule

bind fenwick_range_add_point_query_top fwra_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_point_value (m_point_value)
);

// ----- test/fenwick_range_add_point_query_checker.sv -----
`timescale 1ns / 1ps

module fenwick_range_add_point_query_checker
    import fwra_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_operation,
    input  logic [IDX_W-1:0]        s_left_index,
    input  logic [IDX_W-1:0]        s_right_index,
    input  logic signed [VAL_W-1:0] s_add_value,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [SUM_W-1:0] m_point_value,
    output int                      fail_count,
    output int                      pending_count
);

    // walk index wide enough for right index + 1 and the upward step past the size
    typedef logic [NODE_W:0] walk_idx_t;

    // shadow copy of the difference tree, node k at entry k
    logic [SUM_W-1:0]        node_sum [1:MAX_ENTRIES];
    logic [IDX_W-1:0]        size_reg;
    logic signed [SUM_W-1:0] expected_points [$];
    int                      errors = 0;

    function automatic walk_idx_t lowest_bit(input walk_idx_t k);
        return k & (~k + 1'b1);
    endfunction

    // add a delta along the upward chain, stopping past the size in use
    task automatic spread_delta(input walk_idx_t start, input logic [SUM_W-1:0] delta,
                                input walk_idx_t lim);
        walk_idx_t k;
        k = start;
        while (k != 0 && k <= lim) begin
            node_sum[k] = node_sum[k] + delta;
            k = k + lowest_bit(k);
        end
    endtask

    // sum along the downward chain gives the point value
    function automatic logic [SUM_W-1:0] prefix_total(input walk_idx_t start);
        walk_idx_t        k;
        logic [SUM_W-1:0] acc;
        k   = start;
        acc = '0;
        while (k != 0) begin
            acc = acc + node_sum[k];
            k   = k - lowest_bit(k);
        end
        return acc;
    endfunction

    always @(posedge aclk) begin : predict_and_compare
        walk_idx_t               lim;
        walk_idx_t               first;
        walk_idx_t               second;
        logic [SUM_W-1:0]        delta;
        logic signed [SUM_W-1:0] want;
        if (!aresetn) begin
            for (int i = 1; i <= MAX_ENTRIES; i++) begin
                node_sum[i] = '0;
            end
            size_reg = SIZE_RESET;
            expected_points.delete();
        end else begin
            // result word against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected point value word, expected none, actual %0d",
                             $time, m_point_value);
                end else begin
                    want = expected_points.pop_front();
                    if (m_point_value !== want) begin
                        errors++;
                        $display("%0t: point value mismatch, expected %0d, actual %0d",
                                 $time, want, m_point_value);
                    end
                end
            end
            // accepted input word updates the shadow tree or queues a point value
            if (s_valid && s_ready) begin
                lim   = (size_reg > MAX_ENTRIES) ? walk_idx_t'(MAX_ENTRIES)
                                                 : walk_idx_t'(size_reg);
                first = walk_idx_t'(s_left_index);
                if (op_t'(s_operation) == OP_ADD) begin
                    second = walk_idx_t'(s_right_index) + 1'b1;
                    if (s_left_index != 0 && s_left_index <= s_right_index) begin
                        delta = {{(SUM_W-VAL_W){s_add_value[VAL_W-1]}}, s_add_value};
                        spread_delta(first, delta, lim);
                        spread_delta(second, -delta, lim);
                    end
                end else begin
                    if (first > lim) begin
                        first = lim;
                    end
                    expected_points.insert(expected_points.size(), prefix_total(first));
                end
            end
            // size change keeps the stored sums
            if (cfg_wr_en) begin
                size_reg = cfg_wr_data;
            end
        end
        fail_count    <= errors;
        pending_count <= expected_points.size();
    end

endmodule

// ----- test/fenwick_range_add_point_query_top_tb.sv -----
`timescale 1ns / 1ps

module fenwick_range_add_point_query_top_tb;
    import fwra_pkg::*;

    localparam int MAX_ENTRIES     = 4096;
    localparam int DRAIN_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 160;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]        cfg_wr_data   = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic                    s_operation   = 1'b0;
    logic [IDX_W-1:0]        s_left_index  = '0;
    logic [IDX_W-1:0]        s_right_index = '0;
    logic signed [VAL_W-1:0] s_add_value   = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic signed [SUM_W-1:0] m_point_value;

    int fail_count;
    int pending_count;
    int idle_cycles = 0;
    int sent_words  = 0;
    int words_taken = 0;
    int cur_size    = 4096;

    always #6 aclk = ~aclk;

    fenwick_range_add_point_query_top #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_left_index  (s_left_index),
        .s_right_index (s_right_index),
        .s_add_value   (s_add_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_value (m_point_value)
    );

    fenwick_range_add_point_query_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_left_index  (s_left_index),
        .s_right_index (s_right_index),
        .s_add_value   (s_add_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_value (m_point_value),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // offer one word after a random gap and hold it until accepted
    task automatic send_word(input op_t op, input logic [IDX_W-1:0] left_idx,
                             input logic [IDX_W-1:0] right_idx, input logic [VAL_W-1:0] val);
        int gap;
        gap = ((sent_words % 80) < 20) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_left_index  <= left_idx;
        s_right_index <= right_idx;
        s_add_value   <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_words++;
    endtask

    // stop offering, let every point value arrive and the back end finish its adds
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_size(input logic [IDX_W-1:0] size);
        wait_for_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_size     = size;
    endtask

    // index biased toward the live positions, with zero, the size and noise mixed in
    function automatic logic [IDX_W-1:0] pick_index(input int eff);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            return '0;
        end else if (roll < 12) begin
            return IDX_W'(eff);
        end else if (roll < 18 || eff == 0) begin
            return IDX_W'($urandom_range(0, 8191));
        end else begin
            return IDX_W'($urandom_range(1, eff));
        end
    endfunction

    task automatic random_word();
        int                eff;
        int                roll;
        int                span;
        int                reach;
        logic [IDX_W-1:0]  left_idx;
        logic [IDX_W-1:0]  right_idx;
        logic [VAL_W-1:0]  val;
        op_t               op;
        eff      = (cur_size > MAX_ENTRIES) ? MAX_ENTRIES : cur_size;
        left_idx = pick_index(eff);
        roll     = $urandom_range(0, 99);
        if (roll < 8) begin
            right_idx = IDX_W'($urandom_range(0, 8191));
        end else if (roll < 14) begin
            // reversed range
            right_idx = (left_idx > 0) ? IDX_W'($urandom_range(0, left_idx - 1)) : '0;
        end else begin
            span      = ($urandom_range(0, 3) == 0) ? eff : 32;
            reach     = left_idx + $urandom_range(0, span);
            right_idx = (reach > 8191) ? 13'd8191 : IDX_W'(reach);
        end
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    val = 32'h7FFF_FFFF;
                end
                1: begin
                    val = 32'h8000_0000;
                end
                2: begin
                    val = '0;
                end
                default: begin
                    val = '1;
                end
            endcase
        end else begin
            val = $urandom;
        end
        op = ($urandom_range(0, 99) < 40) ? OP_QUERY : OP_ADD;
        send_word(op, left_idx, right_idx, val);
    endtask

    // extremes of the fields and the edge cases of adds and queries at full size
    task automatic directed_words();
        send_word(OP_QUERY, 13'd0,    13'd0,    32'h0);
        send_word(OP_QUERY, 13'd1,    13'd0,    32'h0);
        send_word(OP_QUERY, 13'd4096, 13'd0,    32'h0);
        send_word(OP_QUERY, 13'd8191, 13'd8191, 32'hFFFF_FFFF);
        send_word(OP_ADD,   13'd1,    13'd4096, 32'h7FFF_FFFF);
        send_word(OP_ADD,   13'd1,    13'd4096, 32'h8000_0000);
        send_word(OP_ADD,   13'd0,    13'd5,    32'h0000_1234);
        send_word(OP_ADD,   13'd10,   13'd5,    32'h0000_0077);
        send_word(OP_ADD,   13'd1,    13'd0,    32'h0000_0011);
        send_word(OP_ADD,   13'd0,    13'd0,    32'h0000_0022);
        send_word(OP_ADD,   13'd4096, 13'd4096, 32'hFFFF_FFFF);
        send_word(OP_ADD,   13'd8191, 13'd8191, 32'h0000_0100);
        send_word(OP_ADD,   13'd1,    13'd1,    32'h0000_0005);
        send_word(OP_ADD,   13'd4095, 13'd8191, 32'h0000_3039);
        send_word(OP_ADD,   13'd2047, 13'd2049, 32'h8000_0000);
        send_word(OP_QUERY, 13'd1,    13'd0,    32'h0);
        send_word(OP_QUERY, 13'd2,    13'd0,    32'h0);
        send_word(OP_QUERY, 13'd2048, 13'd0,    32'h0);
        send_word(OP_QUERY, 13'd4095, 13'd0,    32'h0);
        send_word(OP_QUERY, 13'd4096, 13'd0,    32'h0);
        send_word(OP_QUERY, 13'd8191, 13'd0,    32'h0);
        send_word(OP_QUERY, 13'd0,    13'd8191, 32'h7FFF_FFFF);
    endtask

    // reset, directed words, then random phases over several sizes
    initial begin : stimulus
        logic [IDX_W-1:0] sizes [9];
        sizes = '{13'd1, 13'd0, 13'd8191, 13'd4095, 13'd4097, 13'd13, 13'd2048,
                  13'd1, 13'd4096};
        sizes[7] = IDX_W'($urandom_range(1, 4096));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        directed_words();
        repeat (ITEMS_PER_PHASE) random_word();
        foreach (sizes[i]) begin
            set_size(sizes[i]);
            repeat (ITEMS_PER_PHASE) random_word();
        end
        wait_for_idle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS fenwick_range_add_point_query_top");
        end else begin
            $display("FAIL fenwick_range_add_point_query_top");
        end
        $finish;
    end

    // result side: random gaps, no-gap stretches, and two long hold-offs
    initial begin : result_sink
        int gap;
        forever begin
            if (words_taken == 40 || words_taken == 400) begin
                gap = HOLD_OFF_CYCLES;
            end else if ((words_taken % 50) < 12) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            words_taken++;
        end
    end

    // cycles since the last accepted word on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL fenwick_range_add_point_query_top");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/fwra_pkg.sv
hdl/fwra_front.sv
hdl/fwra_queue.sv
hdl/fwra_back.sv
hdl/fenwick_range_add_point_query_top.sv
hdl/fwra_checker.sv
test/fenwick_range_add_point_query_checker.sv
test/fenwick_range_add_point_query_top_tb.sv
